// ===== rtl/cpmc_pkg.sv =====
// ----------------------------------------------------------------------------
// cpmc_pkg
// widths, reset values, register indexes and controller states shared by the
// cascaded position/speed controller
// ----------------------------------------------------------------------------
package cpmc_pkg;

    // word fields
    localparam int TARGET_W    = 7;
    localparam int COUNT_W     = 16;
    localparam int DRIVE_W     = 32;

    // configuration port
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    // configuration register widths
    localparam int STEPS_W     = 15;
    localparam int GAIN_W      = 8;
    localparam int IGAIN_W     = 16;
    localparam int ILIM_W      = 16;
    localparam int CUTOFF_W    = 8;
    localparam int OFFSET_W    = 12;
    localparam int JITTER_W    = 8;

    // internal datapath widths
    localparam int DIVIDEND_W  = 22;                  // |count| * 100 < 2^22
    localparam int SUM_W       = 32;
    localparam int MAG_W       = 32;
    localparam int IPROD_W     = MAG_W + IGAIN_W;
    localparam int SPROD_W     = MAG_W + GAIN_W;
    localparam int E_W         = 24;
    localparam int ICL_W       = ILIM_W + 2;
    localparam int SPD_W       = 23;
    localparam int BASE_W      = 24;
    localparam int SREF_W      = 34;
    localparam int DIFF_W      = 35;
    localparam int U_W         = 42;

    // reset values
    localparam logic [STEPS_W-1:0]  TOTAL_STEPS_RST  = STEPS_W'(8192);
    localparam logic [GAIN_W-1:0]   POS_GAIN_RST     = GAIN_W'(6);
    localparam logic [IGAIN_W-1:0]  IGAIN_RST        = IGAIN_W'(492);
    localparam logic [ILIM_W-1:0]   ILIM_RST         = ILIM_W'(2000);
    localparam logic [CUTOFF_W-1:0] CUTOFF_RST       = CUTOFF_W'(20);
    localparam logic [GAIN_W-1:0]   SPEED_GAIN_RST   = GAIN_W'(15);
    localparam logic [OFFSET_W-1:0] OFFSET_RST       = OFFSET_W'(700);
    localparam logic [JITTER_W-1:0] JITTER_RST       = JITTER_W'(2);

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_TOTAL_STEPS      = 3'd0,
        REG_POS_GAIN         = 3'd1,
        REG_INTEGRAL_GAIN    = 3'd2,
        REG_INTEGRAL_LIMIT   = 3'd3,
        REG_INTEGRAL_CUTOFF  = 3'd4,
        REG_SPEED_GAIN       = 3'd5,
        REG_DEAD_ZONE_OFFSET = 3'd6,
        REG_JITTER_BAND      = 3'd7
    } cfg_reg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV,
        ST_ERR,
        ST_PSTART,
        ST_PMUL,
        ST_SREF,
        ST_SSTART,
        ST_SMUL,
        ST_DRIVE,
        ST_SHAPE,
        ST_DONE
    } cpmc_state_t;

endpackage

// ===== rtl/cpmc_if.sv =====
// ----------------------------------------------------------------------------
// cpmc_if
// valid/ready channels for the tick word and the drive word
// ----------------------------------------------------------------------------
interface cpmc_tick_if
    import cpmc_pkg::*;
;
    logic                       valid;
    logic                       ready;
    logic [TARGET_W-1:0]        target_position;
    logic signed [COUNT_W-1:0]  encoder_count;

    modport source (output valid, output target_position, output encoder_count,
                    input ready);
    modport sink   (input valid, input target_position, input encoder_count,
                    output ready);
endinterface

interface cpmc_drive_if
    import cpmc_pkg::*;
;
    logic                       valid;
    logic                       ready;
    logic signed [DRIVE_W-1:0]  drive_value;

    modport source (output valid, output drive_value, input ready);
    modport sink   (input valid, input drive_value, output ready);
endinterface

// ===== rtl/cpmc_div.sv =====
// ----------------------------------------------------------------------------
// cpmc_div
// bit-serial restoring divider, one quotient bit per cycle, unsigned
// ----------------------------------------------------------------------------
module cpmc_div
    import cpmc_pkg::*;
#(
    parameter int NUM_W = DIVIDEND_W,
    parameter int DEN_W = STEPS_W
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] dividend,
    input  logic [DEN_W-1:0] divisor,
    output logic             busy,
    output logic             last,
    output logic [NUM_W-1:0] quotient
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [CNT_W-1:0] cnt_reg;
    logic [NUM_W-1:0] quo_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] den_reg;
    logic [DEN_W:0]   trial;
    logic             fits;

    // shift next dividend bit into the partial remainder and try the subtract
    assign trial = {rem_reg, quo_reg[NUM_W-1]};
    assign fits  = trial >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (start)
        begin
            cnt_reg <= CNT_W'(NUM_W);
        end
        else if (busy)
        begin
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            den_reg <= divisor;
        end
        else if (busy)
        begin
            quo_reg <= {quo_reg[NUM_W-2:0], fits};
            rem_reg <= fits ? DEN_W'(trial - {1'b0, den_reg}) : trial[DEN_W-1:0];
        end
    end

    assign busy     = cnt_reg != '0;
    assign last     = cnt_reg == CNT_W'(1);
    assign quotient = quo_reg;

endmodule

// ===== rtl/cpmc_mul.sv =====
// ----------------------------------------------------------------------------
// cpmc_mul
// bit-serial shift-add multiplier, one multiplier bit per cycle, unsigned
// ----------------------------------------------------------------------------
module cpmc_mul
    import cpmc_pkg::*;
#(
    parameter int A_W = MAG_W,
    parameter int B_W = GAIN_W
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [A_W-1:0]       a,
    input  logic [B_W-1:0]       b,
    output logic                 busy,
    output logic                 last,
    output logic [A_W+B_W-1:0]   product
);

    localparam int CNT_W = $clog2(B_W + 1);

    logic [CNT_W-1:0]     cnt_reg;
    logic [A_W-1:0]       a_reg;
    logic [A_W+B_W-1:0]   acc_reg;
    logic [A_W:0]         part;

    // upper half plus multiplicand when the current multiplier bit is set
    assign part = acc_reg[0] ? ({1'b0, acc_reg[A_W+B_W-1:B_W]} + {1'b0, a_reg})
                             : {1'b0, acc_reg[A_W+B_W-1:B_W]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (start)
        begin
            cnt_reg <= CNT_W'(B_W);
        end
        else if (busy)
        begin
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg   <= a;
            acc_reg <= {{A_W{1'b0}}, b};
        end
        else if (busy)
        begin
            acc_reg <= {part, acc_reg[B_W-1:1]};
        end
    end

    assign busy    = cnt_reg != '0;
    assign last    = cnt_reg == CNT_W'(1);
    assign product = acc_reg;

endmodule

// ===== rtl/cascaded_pi_motor_position_control.sv =====
// ----------------------------------------------------------------------------
// cascaded_pi_motor_position_control
// cascaded position PI / speed P motor controller with dead-zone shaping
// ----------------------------------------------------------------------------
// One tick word (target in percent, raw encoder count) gives one drive word.
// The count is scaled to percent by a bit-serial divider while a
// bit-serial multiplier forms the integral term from the stored error sum,
// hidden under the division. A second bit-serial multiplier is then used
// twice, once for the position gain and once for the speed gain, with
// registered steps for the error before it, for the sums between and after
// the passes, and for the dead zone and saturation at the end. A new word is
// taken only once the previous one has been loaded into the drive register,
// in the cycle after that load. A new tick word is
// taken even while the previous drive word is still waiting on the output
// side; its own drive word then holds in the last stage until the output
// register is free. The divider length and the two passes through the gain
// multiplier set how long a word takes. Configuration registers are written
// through cfg_we / cfg_index / cfg_data and should only change while no tick
// is in flight.
// ----------------------------------------------------------------------------
module cascaded_pi_motor_position_control
    import cpmc_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    cpmc_tick_if.sink              tick,
    cpmc_drive_if.source           drive,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    // configuration registers
    logic [STEPS_W-1:0]  total_steps_reg;
    logic [GAIN_W-1:0]   pos_gain_reg;
    logic [IGAIN_W-1:0]  integral_gain_q16_reg;
    logic [ILIM_W-1:0]   integral_limit_reg;
    logic [CUTOFF_W-1:0] integral_cutoff_reg;
    logic [GAIN_W-1:0]   speed_gain_reg;
    logic [OFFSET_W-1:0] dead_zone_offset_reg;
    logic [JITTER_W-1:0] jitter_band_reg;

    // controller state carried between ticks
    logic signed [COUNT_W-1:0] prev_count_reg;
    logic signed [SUM_W-1:0]   sum_reg;
    logic signed [SUM_W-1:0]   sum_next;

    // sequencer
    cpmc_state_t state_reg;
    cpmc_state_t state_next;
    logic        tick_accept;
    logic        in_ready;
    logic        div_start;
    logic        imul_start;
    logic        smul_start;
    logic        out_load;
    logic        out_valid_reg;

    // latched tick word
    logic [TARGET_W-1:0]       target_reg;
    logic signed [COUNT_W-1:0] count_reg;

    // datapath registers
    logic signed [E_W-1:0]     e_reg;
    logic signed [ICL_W-1:0]   iclamp_reg;
    logic signed [ICL_W-1:0]   integ_reg;
    logic signed [SPD_W-1:0]   spd_reg;
    logic signed [BASE_W-1:0]  base_reg;
    logic signed [SREF_W-1:0]  sref_reg;
    logic signed [DIFF_W-1:0]  diff_reg;
    logic signed [U_W-1:0]     u_reg;
    logic signed [U_W-1:0]     shaped_reg;
    logic signed [DRIVE_W-1:0] drive_reg;

    logic signed [E_W-1:0]     e_next;
    logic signed [ICL_W-1:0]   iclamp_next;
    logic signed [ICL_W-1:0]   integ_next;
    logic signed [SPD_W-1:0]   spd_next;
    logic signed [BASE_W-1:0]  base_next;
    logic signed [SREF_W-1:0]  sref_next;
    logic signed [DIFF_W-1:0]  diff_next;
    logic signed [U_W-1:0]     u_next;
    logic signed [U_W-1:0]     shaped_next;
    logic signed [DRIVE_W-1:0] drive_next;

    // serial unit connections
    logic [DIVIDEND_W-1:0] div_dividend;
    logic [STEPS_W-1:0]    div_divisor;
    logic                  div_busy;
    logic                  div_last;
    logic [DIVIDEND_W-1:0] div_quot;
    logic [MAG_W-1:0]      sum_mag;
    logic                  imul_busy;
    logic                  imul_last;
    logic [IPROD_W-1:0]    imul_prod;
    logic [MAG_W-1:0]      smul_a;
    logic [GAIN_W-1:0]     smul_b;
    logic                  smul_busy;
    logic                  smul_last;
    logic [SPROD_W-1:0]    smul_prod;

    // helpers
    logic signed [DIVIDEND_W+1:0] count_ext;
    logic signed [DIVIDEND_W+1:0] count_x100;
    logic signed [DIVIDEND_W+1:0] count_x100_abs;
    logic signed [E_W-1:0]        target_ext;
    logic signed [E_W-1:0]        quot_ext;
    logic [MAG_W-1:0]             iq;
    logic [ILIM_W-1:0]            iq_cl;
    logic signed [ICL_W-1:0]      iq_ext;
    logic signed [COUNT_W:0]      delta;
    logic signed [SPD_W-1:0]      delta_ext;
    logic signed [E_W-1:0]        e_abs;
    logic signed [SREF_W-1:0]     p_ext;
    logic signed [SREF_W-1:0]     p_signed;
    logic signed [DIFF_W-1:0]     diff_abs;
    logic signed [U_W-1:0]        q_ext;
    logic signed [U_W-1:0]        off_ext;
    logic signed [U_W-1:0]        jit_ext;
    logic signed [SUM_W:0]        sum_wide;

    // ------------------------------------------------------------------
    // configuration port
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_steps_reg       <= TOTAL_STEPS_RST;
            pos_gain_reg          <= POS_GAIN_RST;
            integral_gain_q16_reg <= IGAIN_RST;
            integral_limit_reg    <= ILIM_RST;
            integral_cutoff_reg   <= CUTOFF_RST;
            speed_gain_reg        <= SPEED_GAIN_RST;
            dead_zone_offset_reg  <= OFFSET_RST;
            jitter_band_reg       <= JITTER_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_TOTAL_STEPS:      total_steps_reg       <= cfg_data[STEPS_W-1:0];
                REG_POS_GAIN:         pos_gain_reg          <= cfg_data[GAIN_W-1:0];
                REG_INTEGRAL_GAIN:    integral_gain_q16_reg <= cfg_data[IGAIN_W-1:0];
                REG_INTEGRAL_LIMIT:   integral_limit_reg    <= cfg_data[ILIM_W-1:0];
                REG_INTEGRAL_CUTOFF:  integral_cutoff_reg   <= cfg_data[CUTOFF_W-1:0];
                REG_SPEED_GAIN:       speed_gain_reg        <= cfg_data[GAIN_W-1:0];
                REG_DEAD_ZONE_OFFSET: dead_zone_offset_reg  <= cfg_data[OFFSET_W-1:0];
                REG_JITTER_BAND:      jitter_band_reg       <= cfg_data[JITTER_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // sequencer: next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (tick_accept) state_next = ST_DIV;
            ST_DIV:    if (div_last)    state_next = ST_ERR;
            ST_ERR:    state_next = ST_PSTART;
            ST_PSTART: state_next = ST_PMUL;
            ST_PMUL:   if (smul_last)   state_next = ST_SREF;
            ST_SREF:   state_next = ST_SSTART;
            ST_SSTART: state_next = ST_SMUL;
            ST_SMUL:   if (smul_last)   state_next = ST_DRIVE;
            ST_DRIVE:  state_next = ST_SHAPE;
            ST_SHAPE:  state_next = ST_DONE;
            ST_DONE:   if (out_load)    state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // sequencer: outputs
    // ------------------------------------------------------------------
    always_comb
    begin
        in_ready   = 1'b0;
        smul_start = 1'b0;
        out_load   = 1'b0;
        case (state_reg)
            ST_IDLE:   in_ready   = 1'b1;
            ST_PSTART: smul_start = 1'b1;
            ST_SSTART: smul_start = 1'b1;
            ST_DONE:   out_load   = !out_valid_reg || drive.ready;
            default: ;
        endcase
    end

    assign tick.ready  = in_ready;
    assign tick_accept = tick.valid && in_ready;
    // divider and integral multiplier run side by side from acceptance
    assign div_start   = tick_accept;
    assign imul_start  = tick_accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // ------------------------------------------------------------------
    // percent scaling: |count * 100| / total_steps
    // ------------------------------------------------------------------
    assign count_ext      = (DIVIDEND_W+2)'(tick.encoder_count);
    assign count_x100     = (count_ext <<< 6) + (count_ext <<< 5) + (count_ext <<< 2);
    assign count_x100_abs = count_x100[DIVIDEND_W+1] ? -count_x100 : count_x100;
    assign div_dividend   = count_x100_abs[DIVIDEND_W-1:0];
    // a step count of zero is taken as one
    assign div_divisor    = (total_steps_reg == '0) ? STEPS_W'(1) : total_steps_reg;

    cpmc_div #(
        .NUM_W (DIVIDEND_W),
        .DEN_W (STEPS_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .last     (div_last),
        .quotient (div_quot)
    );

    // ------------------------------------------------------------------
    // integral term: |sum| * gain, Q16 fraction dropped
    // ------------------------------------------------------------------
    assign sum_mag = sum_reg[SUM_W-1] ? MAG_W'(-sum_reg) : MAG_W'(sum_reg);

    cpmc_mul #(
        .A_W (MAG_W),
        .B_W (IGAIN_W)
    ) u_imul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (imul_start),
        .a       (sum_mag),
        .b       (integral_gain_q16_reg),
        .busy    (imul_busy),
        .last    (imul_last),
        .product (imul_prod)
    );

    // ------------------------------------------------------------------
    // shared gain multiplier: position gain first, then speed gain
    // ------------------------------------------------------------------
    assign e_abs    = e_reg[E_W-1] ? -e_reg : e_reg;
    assign diff_abs = diff_reg[DIFF_W-1] ? -diff_reg : diff_reg;
    assign smul_a   = (state_reg == ST_SSTART) ? diff_abs[MAG_W-1:0]
                                               : MAG_W'(unsigned'(e_abs));
    assign smul_b   = (state_reg == ST_SSTART) ? speed_gain_reg : pos_gain_reg;

    cpmc_mul #(
        .A_W (MAG_W),
        .B_W (GAIN_W)
    ) u_smul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (smul_start),
        .a       (smul_a),
        .b       (smul_b),
        .busy    (smul_busy),
        .last    (smul_last),
        .product (smul_prod)
    );

    // ------------------------------------------------------------------
    // datapath arithmetic
    // ------------------------------------------------------------------
    always_comb
    begin
        // position error, quotient sign follows the count sign
        target_ext = $signed({{(E_W-TARGET_W){1'b0}}, target_reg});
        quot_ext   = $signed({{(E_W-DIVIDEND_W){1'b0}}, div_quot});
        e_next     = count_reg[COUNT_W-1] ? target_ext + quot_ext : target_ext - quot_ext;

        // integral magnitude clamp, sign restored from the error sum
        iq          = imul_prod[IPROD_W-1:IGAIN_W];
        iq_cl       = (iq > MAG_W'(integral_limit_reg)) ? integral_limit_reg
                                                         : iq[ILIM_W-1:0];
        iq_ext      = $signed({2'b00, iq_cl});
        iclamp_next = sum_reg[SUM_W-1] ? -iq_ext : iq_ext;

        // speed estimate: count change times 20
        delta     = $signed({count_reg[COUNT_W-1], count_reg})
                  - $signed({prev_count_reg[COUNT_W-1], prev_count_reg});
        delta_ext = SPD_W'(delta);
        spd_next  = (delta_ext <<< 4) + (delta_ext <<< 2);

        // integral zeroed for large errors
        integ_next = (unsigned'(e_abs) > E_W'(integral_cutoff_reg)) ? '0 : iclamp_reg;
        base_next  = BASE_W'(integ_reg) - BASE_W'(spd_reg);

        // speed reference and speed error
        p_ext     = $signed({1'b0, smul_prod[SREF_W-2:0]});
        p_signed  = e_reg[E_W-1] ? -p_ext : p_ext;
        sref_next = p_signed + SREF_W'(integ_reg);
        diff_next = DIFF_W'(p_signed) + DIFF_W'(base_reg);

        // speed loop output plus feed-forward of the reference
        q_ext  = $signed({{(U_W-SPROD_W){1'b0}}, smul_prod});
        u_next = (diff_reg[DIFF_W-1] ? -q_ext : q_ext) + U_W'(sref_reg);

        // dead zone with jitter band
        off_ext     = $signed({{(U_W-OFFSET_W){1'b0}}, dead_zone_offset_reg});
        jit_ext     = $signed({{(U_W-JITTER_W){1'b0}}, jitter_band_reg});
        shaped_next = u_reg;
        if (u_reg > 0 && u_reg < off_ext)
        begin
            shaped_next = (u_reg < jit_ext) ? '0 : u_reg + off_ext;
        end
        else if (u_reg < 0 && u_reg > -off_ext)
        begin
            shaped_next = (u_reg > -jit_ext) ? '0 : u_reg - off_ext;
        end

        // saturate to the drive width
        if (shaped_reg[U_W-1:DRIVE_W-1] == '0 || shaped_reg[U_W-1:DRIVE_W-1] == '1)
        begin
            drive_next = shaped_reg[DRIVE_W-1:0];
        end
        else
        begin
            drive_next = shaped_reg[U_W-1] ? $signed({1'b1, {(DRIVE_W-1){1'b0}}})
                                           : $signed({1'b0, {(DRIVE_W-1){1'b1}}});
        end

        // saturating error accumulation
        sum_wide = (SUM_W+1)'(sum_reg) + (SUM_W+1)'(e_reg);
        if (sum_wide[SUM_W] != sum_wide[SUM_W-1])
        begin
            sum_next = sum_wide[SUM_W] ? $signed({1'b1, {(SUM_W-1){1'b0}}})
                                       : $signed({1'b0, {(SUM_W-1){1'b1}}});
        end
        else
        begin
            sum_next = sum_wide[SUM_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // datapath registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (tick_accept)
                begin
                    target_reg <= tick.target_position;
                    count_reg  <= tick.encoder_count;
                end
            end
            ST_ERR:
            begin
                e_reg      <= e_next;
                iclamp_reg <= iclamp_next;
                spd_reg    <= spd_next;
            end
            ST_PSTART: integ_reg <= integ_next;
            ST_PMUL:   base_reg  <= base_next;
            ST_SREF:
            begin
                sref_reg <= sref_next;
                diff_reg <= diff_next;
            end
            ST_DRIVE:  u_reg      <= u_next;
            ST_SHAPE:  shaped_reg <= shaped_next;
            ST_DONE:   if (out_load) drive_reg <= drive_next;
            default: ;
        endcase
    end

    // tick-to-tick state, updated once the speed estimate is taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_count_reg <= '0;
            sum_reg        <= '0;
        end
        else if (state_reg == ST_PSTART)
        begin
            prev_count_reg <= count_reg;
            sum_reg        <= sum_next;
        end
    end

    // ------------------------------------------------------------------
    // output word register
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (drive.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign drive.valid       = out_valid_reg;
    assign drive.drive_value = drive_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    // no serial unit may still be working when a new word can come in
    a_idle_units: assert property (@(posedge clk) disable iff (!rst_n)
        tick.ready |-> (!div_busy && !imul_busy && !smul_busy))
        else $error("serial unit busy while taking a new tick word");

    // the integral product must be complete by the error stage
    a_imul_first: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ERR) |-> !imul_busy)
        else $error("integral product not ready at error stage");

    // the integral multiplier finishes while the division is still running
    a_imul_last: assert property (@(posedge clk) disable iff (!rst_n)
        imul_last |-> (state_reg == ST_DIV))
        else $error("integral product finished outside the division");

    // clamped integral stays inside the limit
    a_iclamp: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PSTART) |->
            (iclamp_reg <= $signed({2'b00, integral_limit_reg}) &&
             iclamp_reg >= -$signed({2'b00, integral_limit_reg})))
        else $error("integral term outside clamp");

    // a loaded drive word is presented on the next cycle
    a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> drive.valid)
        else $error("drive word loaded but not presented");

endmodule
